/* hdl/gff_pkg.sv */
`timescale 1ns / 1ps
package gff_pkg;
  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 64;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int AddrW      = ColW + RowW;
  localparam int CellCount  = MaxWidth * MaxHeight;
  localparam int DepthW     = $clog2(CellCount + 1);
  localparam logic [7:0] FillChar = 8'd70;

  // Configuration register indexes.
  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FILL  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_ISFILL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_RD,
    S_START_CHK,
    S_POP,
    S_POP_WAIT,
    S_NB_RD,
    S_NB_CHK,
    S_DONE
  } state_t;

  // Memory request from the sequencer to the grid store.
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [AddrW-1:0] addr;
    logic [7:0]       wdata;
  } grid_req_t;
endpackage

/* hdl/gff_grid_mem.sv */
`timescale 1ns / 1ps
module gff_grid_mem (
  input  logic                clk,
  input  gff_pkg::grid_req_t  req,
  output logic [7:0]          rdata
);
  import gff_pkg::*;
  logic [7:0] mem [CellCount];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end
endmodule

/* hdl/gff_stack.sv */
`timescale 1ns / 1ps
module gff_stack (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  logic                      push,
  input  logic [gff_pkg::AddrW-1:0] push_data,
  input  logic                      pop,
  output logic [gff_pkg::AddrW-1:0] pop_data,
  output logic                      empty
);
  import gff_pkg::*;
  logic [AddrW-1:0]  mem [CellCount];
  logic [DepthW-1:0] depth_r, depth_nxt;

  assign empty = (depth_r == '0);

  always_comb begin
    depth_nxt = depth_r;
    if (clear) begin
      depth_nxt = '0;
    end else if (push && depth_r < DepthW'(CellCount)) begin
      depth_nxt = depth_r + 1'b1;
    end else if (pop && !empty) begin
      depth_nxt = depth_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // Push and pop never happen in the same cycle.
  always_ff @(posedge clk) begin
    if (push && !clear && depth_r < DepthW'(CellCount)) begin
      mem[depth_r[AddrW-1:0]] <= push_data;
    end
    if (pop) begin
      pop_data <= mem[AddrW'(depth_r - 1'b1)];
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n) !(push && pop))
    else $error("stack push and pop together");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DepthW'(CellCount)) else $error("stack depth overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop of empty stack");
`endif
endmodule

/* hdl/gff_seq.sv */
`timescale 1ns / 1ps
module gff_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [6:0]                cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_kind,
  input  logic [5:0]                in_col,
  input  logic [5:0]                in_row,
  input  logic [7:0]                in_cell_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_read_value,
  output logic [12:0]               out_filled_count,
  output logic [1:0]                out_status,
  output gff_pkg::grid_req_t        mreq,
  input  logic [7:0]                mrdata,
  output logic                      sclear,
  output logic                      spush,
  output logic [gff_pkg::AddrW-1:0] spush_data,
  output logic                      spop,
  input  logic [gff_pkg::AddrW-1:0] spop_data,
  input  logic                      sempty
);
  import gff_pkg::*;
  state_t state_r, state_nxt;
  logic [6:0] width_r, height_r;
  logic [1:0] kind_r;
  logic [ColW-1:0] col_r, cc_r;
  logic [RowW-1:0] row_r, cr_r;
  logic [7:0] val_r, target_r;
  logic [1:0] dir_r;
  logic [12:0] count_r;
  logic [7:0] rd_r;
  logic [1:0] st_r;
  logic [ColW:0] nb_c;
  logic [RowW:0] nb_r;
  logic nb_in, in_in;
  logic [6:0] uw, uh;

  assign uw = (width_r > 7'(MaxWidth)) ? 7'(MaxWidth) : width_r;
  assign uh = (height_r > 7'(MaxHeight)) ? 7'(MaxHeight) : height_r;
  assign in_in = ({1'b0, col_r} < uw) && ({1'b0, row_r} < uh);

  // Neighbor order: right, left, down, up; wrap below zero lands outside.
  always_comb begin
    nb_c = {1'b0, cc_r};
    nb_r = {1'b0, cr_r};
    case (dir_r)
      2'd0: nb_c = {1'b0, cc_r} + 1'b1;
      2'd1: nb_c = {1'b0, cc_r} - 1'b1;
      2'd2: nb_r = {1'b0, cr_r} + 1'b1;
      default: nb_r = {1'b0, cr_r} - 1'b1;
    endcase
  end
  assign nb_in = !nb_c[ColW] && !nb_r[RowW] && (7'(nb_c) < uw) && (7'(nb_r) < uh);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_START_RD;
      S_START_RD: begin
        if (!in_in || kind_t'(kind_r) == KIND_WRITE || kind_t'(kind_r) == KIND_NONE) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_START_CHK;
        end
      end
      S_START_CHK: begin
        if (kind_t'(kind_r) == KIND_READ || mrdata == FillChar) state_nxt = S_DONE;
        else state_nxt = S_POP;
      end
      S_POP: state_nxt = sempty ? S_DONE : S_POP_WAIT;
      S_POP_WAIT: state_nxt = S_NB_RD;
      S_NB_RD: begin
        if (nb_in) state_nxt = S_NB_CHK;
        else if (dir_r == 2'd3) state_nxt = S_POP;
      end
      S_NB_CHK: state_nxt = (dir_r == 2'd3) ? S_POP : S_NB_RD;
      S_DONE: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mreq = '0;
    sclear = 1'b0;
    spush = 1'b0;
    spush_data = {cr_r, cc_r};
    spop = 1'b0;
    unique case (state_r)
      S_START_RD: begin
        mreq.addr = {row_r, col_r};
        mreq.wdata = val_r;
        mreq.rd = in_in && kind_t'(kind_r) != KIND_WRITE;
        mreq.wr = in_in && kind_t'(kind_r) == KIND_WRITE;
        sclear = 1'b1;
      end
      S_START_CHK: begin
        mreq.addr = {row_r, col_r};
        mreq.wdata = FillChar;
        if (kind_t'(kind_r) == KIND_FILL && mrdata != FillChar) begin
          mreq.wr = 1'b1;
          spush = 1'b1;
          spush_data = {row_r, col_r};
        end
      end
      S_POP: spop = !sempty;
      S_NB_RD: begin
        mreq.addr = {RowW'(nb_r), ColW'(nb_c)};
        mreq.rd = nb_in;
      end
      S_NB_CHK: begin
        mreq.addr = {RowW'(nb_r), ColW'(nb_c)};
        mreq.wdata = FillChar;
        if (mrdata == target_r) begin
          mreq.wr = 1'b1;
          spush = 1'b1;
          spush_data = {RowW'(nb_r), ColW'(nb_c)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      width_r <= 7'd64;
      height_r <= 7'd64;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == REG_WIDTH) width_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_HEIGHT) height_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_valid) begin
        kind_r <= in_kind;
        col_r <= in_col;
        row_r <= in_row;
        val_r <= in_cell_value;
        rd_r <= '0;
        count_r <= '0;
        st_r <= ST_OK;
      end
      S_START_RD: if (!in_in && kind_t'(kind_r) != KIND_NONE) st_r <= ST_OUTSIDE;
      S_START_CHK: begin
        target_r <= mrdata;
        if (kind_t'(kind_r) == KIND_READ) rd_r <= mrdata;
        else if (mrdata == FillChar) st_r <= ST_ISFILL;
        else count_r <= 13'd1;
      end
      S_POP_WAIT: ;
      S_NB_RD: begin
        if (!nb_in) dir_r <= dir_r + 1'b1;
      end
      S_NB_CHK: begin
        dir_r <= dir_r + 1'b1;
        if (mrdata == target_r) count_r <= count_r + 1'b1;
      end
      default: ;
    endcase
    if (state_r == S_POP_WAIT) begin
      cc_r <= spop_data[ColW-1:0];
      cr_r <= spop_data[AddrW-1:ColW];
      dir_r <= 2'd0;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_read_value = rd_r;
  assign out_filled_count = count_r;
  assign out_status = st_r;

`ifndef NO_ASSERTIONS
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result shown while idle");
  a_fill_only_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind_t'(kind_r) != KIND_FILL) |-> out_filled_count == '0)
    else $error("count on non-fill item");
  a_no_rw_together: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.rd && mreq.wr)) else $error("grid read and write together");
  a_push_writes: assert property (@(posedge clk) disable iff (!rst_n)
    spush |-> (mreq.wr && mreq.wdata == FillChar)) else $error("push without mark");
`endif
endmodule

/* hdl/grid_flood_fill.sv */
`timescale 1ns / 1ps
// Four-connected flood fill over a 64 x 64 grid of 8-bit cells held in one
// single-port memory, with a pending-cell stack in a second memory. One item
// is handled at a time and the input is stalled meanwhile. A fill pops each
// pending cell and probes its neighbors inside the grid, each probe using the
// single grid memory port for a read and then, on a match, a mark. Results
// hold until taken.
module grid_flood_fill (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_col,
  input  logic [5:0]  in_row,
  input  logic [7:0]  in_cell_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_value,
  output logic [12:0] out_filled_count,
  output logic [1:0]  out_status
);
  import gff_pkg::*;
  grid_req_t mreq;
  logic [7:0] mrdata;
  logic sclear, spush, spop, sempty;
  logic [AddrW-1:0] spush_data, spop_data;

  gff_grid_mem u_mem (.clk(clk), .req(mreq), .rdata(mrdata));

  gff_stack u_stack (
    .clk(clk), .rst_n(rst_n), .clear(sclear), .push(spush),
    .push_data(spush_data), .pop(spop), .pop_data(spop_data), .empty(sempty)
  );

  gff_seq u_seq (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_col(in_col), .in_row(in_row),
    .in_cell_value(in_cell_value), .out_valid(out_valid), .out_stall(out_stall),
    .out_read_value(out_read_value), .out_filled_count(out_filled_count),
    .out_status(out_status), .mreq(mreq), .mrdata(mrdata), .sclear(sclear),
    .spush(spush), .spush_data(spush_data), .spop(spop), .spop_data(spop_data),
    .sempty(sempty)
  );
endmodule

/* tb/sv/grid_flood_fill_tb.sv */
`timescale 1ns / 1ps
module grid_flood_fill_tb;
  import gff_pkg::*;

  localparam int CycleLimit = 3000000;

  typedef struct {
    kind_t      kind;
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] value;
  } cell_op_t;

  typedef struct {
    logic [7:0]  read_value;
    logic [12:0] filled_count;
    status_t     status;
  } cell_reply_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [6:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [5:0]  in_col;
  logic [5:0]  in_row;
  logic [7:0]  in_cell_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_value;
  logic [12:0] out_filled_count;
  logic [1:0]  out_status;

  grid_flood_fill dut (.*);

  cell_op_t    op_queue[$];
  cell_reply_t reply_queue[$];
  cell_op_t    op_on_bus;
  logic [7:0]  shadow_grid [CellCount];
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;
  int          fail_count = 0;
  int          send_gap;
  int          hold_left;
  int          words_taken;
  bit          long_hold_done;
  int          cycle_count = 0;
  logic [7:0]  palette [3];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int used_width();
    return (width_reg > MaxWidth) ? MaxWidth : int'(width_reg);
  endfunction

  function automatic int used_height();
    return (height_reg > MaxHeight) ? MaxHeight : int'(height_reg);
  endfunction

  function automatic bit in_grid(int c, int r);
    return c >= 0 && r >= 0 && c < used_width() && r < used_height();
  endfunction

  // Cells are marked when pushed, so each one is counted exactly once.
  function automatic logic [12:0] flood_count(int c0, int r0, logic [7:0] target);
    int pending[$];
    int count;
    int idx;
    int c;
    int r;
    int nc;
    int nr;
    count = 1;
    shadow_grid[r0 * MaxWidth + c0] = FillChar;
    pending.push_back(r0 * MaxWidth + c0);
    while (pending.size() > 0) begin
      idx = pending.pop_back();
      c = idx % MaxWidth;
      r = idx / MaxWidth;
      for (int d = 0; d < 4; d++) begin
        nc = c + ((d == 0) ? 1 : (d == 1) ? -1 : 0);
        nr = r + ((d == 2) ? 1 : (d == 3) ? -1 : 0);
        if (in_grid(nc, nr) && shadow_grid[nr * MaxWidth + nc] == target) begin
          shadow_grid[nr * MaxWidth + nc] = FillChar;
          count++;
          pending.push_back(nr * MaxWidth + nc);
        end
      end
    end
    return count[12:0];
  endfunction

  function automatic cell_reply_t predict_reply(cell_op_t op);
    cell_reply_t rep;
    int idx;
    rep = '{8'd0, 13'd0, ST_OK};
    idx = int'(op.row) * MaxWidth + int'(op.col);
    if (op.kind == KIND_NONE) return rep;
    if (!in_grid(op.col, op.row)) begin
      rep.status = ST_OUTSIDE;
    end else if (op.kind == KIND_WRITE) begin
      shadow_grid[idx] = op.value;
    end else if (op.kind == KIND_READ) begin
      rep.read_value = shadow_grid[idx];
    end else if (shadow_grid[idx] == FillChar) begin
      rep.status = ST_ISFILL;
    end else begin
      rep.filled_count = flood_count(op.col, op.row, shadow_grid[idx]);
    end
    return rep;
  endfunction

  task automatic add_op(kind_t k, int c, int r, int v);
    op_queue.push_back('{k, c[5:0], r[5:0], v[7:0]});
  endtask

  function automatic logic [7:0] pick_value();
    return ($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 2)]
                                       : 8'($urandom);
  endfunction

  // Every cell in use gets written before anything reads or fills it.
  task automatic seed_area(bit uniform, logic [7:0] base);
    for (int r = 0; r < used_height(); r++)
      for (int c = 0; c < used_width(); c++)
        add_op(KIND_WRITE, c, r, uniform ? base : palette[$urandom_range(0, 2)]);
  endtask

  task automatic add_random_ops(int n);
    int sel;
    int c;
    int r;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      c = $urandom_range(0, used_width() - 1);
      r = $urandom_range(0, used_height() - 1);
      if (sel < 6) begin
        add_op(KIND_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      end else if (sel < 14 && (used_width() < MaxWidth || used_height() < MaxHeight)) begin
        if (used_width() < MaxWidth) c = $urandom_range(used_width(), 63);
        else r = $urandom_range(used_height(), 63);
        add_op(kind_t'($urandom_range(0, 2)), c, r, $urandom);
      end else if (sel < 50) begin
        add_op(KIND_WRITE, c, r, pick_value());
      end else if (sel < 75) begin
        add_op(KIND_READ, c, r, $urandom);
      end else begin
        add_op(KIND_FILL, c, r, $urandom);
      end
    end
  endtask

  // Sampled on the falling edge, after the clocked processes have settled.
  task automatic wait_drained();
    while (op_queue.size() > 0 || in_valid || reply_queue.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_size(logic [6:0] w, logic [6:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  // Sender: items leave the queue in order with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_kind       <= KIND_WRITE;
      in_col        <= '0;
      in_row        <= '0;
      in_cell_value <= '0;
      send_gap      <= 0;
    end else begin
      if (in_valid && !in_stall) reply_queue.push_back(predict_reply(op_on_bus));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          op_on_bus = op_queue.pop_front();
          in_valid      <= 1'b1;
          in_kind       <= op_on_bus.kind;
          in_col        <= op_on_bus.col;
          in_row        <= op_on_bus.row;
          in_cell_value <= op_on_bus.value;
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: send_gap <= 0;
            6, 7, 8: send_gap <= $urandom_range(1, 3);
            default: send_gap <= $urandom_range(10, 40);
          endcase
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word and applies random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall      <= 1'b0;
      hold_left      <= 0;
      words_taken    <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_taken <= words_taken + 1;
        if (reply_queue.size() == 0) begin
          $display("%0t: unexpected word rd=%0d cnt=%0d st=%0d", $time,
                   out_read_value, out_filled_count, out_status);
          fail_count++;
        end else begin
          cell_reply_t want;
          want = reply_queue.pop_front();
          if (out_read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d actual %0d", $time,
                     want.read_value, out_read_value);
            fail_count++;
          end
          if (out_filled_count !== want.filled_count) begin
            $display("%0t: filled_count expected %0d actual %0d", $time,
                     want.filled_count, out_filled_count);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_status);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!long_hold_done && words_taken >= 150) begin
        // One long hold so the block fills up and stalls its input.
        long_hold_done <= 1'b1;
        hold_left      <= 400;
        out_stall      <= 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            out_stall <= 1'b1;
            hold_left <= $urandom_range(0, 3);
          end
          3: begin
            out_stall <= 1'b1;
            hold_left <= $urandom_range(10, 50);
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("grid_flood_fill: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_WIDTH;
    cfg_wdata   = '0;
    width_reg   = 7'd64;
    height_reg  = 7'd64;
    palette[0]  = 8'h00;
    palette[1]  = 8'hA5;
    palette[2]  = FillChar;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Default size: the far corners of the full grid.
    add_op(KIND_WRITE, 63, 63, 8'h33);
    add_op(KIND_READ, 63, 63, 0);
    add_op(KIND_WRITE, 0, 0, 8'hC3);
    add_op(KIND_READ, 0, 0, 0);
    wait_drained();

    // Width above the maximum saturates; the first fill covers every cell.
    set_size(7'd127, 7'd2);
    seed_area(1'b1, 8'h5A);
    add_op(KIND_FILL, 63, 1, 0);
    add_op(KIND_FILL, 0, 0, 0);
    add_op(KIND_READ, 0, 0, 0);
    add_op(KIND_WRITE, 0, 0, 8'hFF);
    add_op(KIND_WRITE, 63, 1, 8'h00);
    add_op(KIND_READ, 0, 0, 8'hFF);
    add_op(KIND_READ, 63, 1, 0);
    add_op(KIND_NONE, 63, 63, 8'hFF);
    add_op(KIND_FILL, 0, 0, 0);
    add_op(KIND_FILL, 63, 1, 0);
    add_op(KIND_WRITE, 62, 0, 8'hAA);
    add_op(KIND_WRITE, 63, 0, 8'h55);
    add_op(KIND_FILL, 63, 0, 0);
    add_op(KIND_READ, 62, 0, 0);
    add_op(KIND_READ, 5, 2, 0);
    add_random_ops(40);
    wait_drained();

    // Zero width: nothing is inside the grid.
    set_size(7'd0, 7'd127);
    add_op(KIND_WRITE, 0, 0, 8'h12);
    add_op(KIND_READ, 0, 0, 0);
    add_op(KIND_FILL, 0, 0, 0);
    add_op(KIND_NONE, 0, 0, 0);
    add_op(KIND_FILL, 63, 63, 0);
    wait_drained();

    set_size(7'd1, 7'd1);
    seed_area(1'b0, 8'h00);
    add_random_ops(15);
    wait_drained();

    set_size(7'd9, 7'd7);
    seed_area(1'b0, 8'h00);
    add_random_ops(60);
    wait_drained();

    set_size(7'd5, 7'd8);
    seed_area(1'b0, 8'h00);
    add_random_ops(30);
    wait_drained();

    if (fail_count == 0) begin
      $display("grid_flood_fill: match");
    end else begin
      $display("grid_flood_fill: mismatch");
    end
    $finish;
  end
endmodule
